>>> src/swfm_pkg.sv
`timescale 1ns / 1ps
// Package for the Sv39 page walk and fault mapper.
// Holds sizes, command and status codes and the request, result and queue types.
package swfm_pkg;

  localparam int unsigned TABLE_SLOTS = 8;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned FREE_DEPTH = 1024;

  localparam int unsigned IDX_W = $clog2(ENTRIES_PER_TABLE);
  localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
  localparam int unsigned NSLOT_W = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned STORE_DEPTH = TABLE_SLOTS * ENTRIES_PER_TABLE;
  localparam int unsigned ADDR_W = SLOT_W + IDX_W;
  localparam int unsigned FCNT_W = $clog2(FREE_DEPTH + 1);
  localparam int unsigned FADDR_W = $clog2(FREE_DEPTH);
  localparam int unsigned PPN_W = 44;
  localparam int unsigned PTE_W = 52;
  localparam int unsigned CFG_W = 45;

  localparam logic [7:0] FLAG_V = 8'h01;
  localparam logic [7:0] LEAF_FLAGS = 8'hD7;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_FAULT  = 2'd1,
    CMD_FREE   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BAD_ADDR  = 3'd2,
    ST_MAPPED    = 3'd3,
    ST_NO_PAGES  = 3'd4,
    ST_NO_SLOTS  = 3'd5,
    ST_REJECTED  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CFG_USER_START = 2'd0,
    CFG_USER_END   = 2'd1,
    CFG_FREE_LOW   = 2'd2,
    CFG_FREE_END   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] vaddr;
    logic [43:0] page_number;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  leaf_flags;
    logic [43:0] leaf_page;
  } out_item_t;

  typedef struct packed {
    cmd_e             op;
    logic             bad;
    logic [IDX_W-1:0] vpn2;
    logic [IDX_W-1:0] vpn1;
    logic [IDX_W-1:0] vpn0;
    logic [PPN_W-1:0] page;
  } q_entry_t;

endpackage

>>> src/swfm_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, request acceptance and classification.
// Depends on swfm_pkg.
module swfm_front import swfm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  input  logic             clearing_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output q_entry_t         q_data_o
);

  logic [38:0] user_start_q;
  logic [39:0] user_end_q;
  logic [43:0] free_low_q;
  logic [44:0] free_end_q;
  logic        well_formed;
  logic        fault_ok;
  logic        free_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_start_q <= '0;
      user_end_q   <= '0;
      free_low_q   <= '0;
      free_end_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_USER_START: user_start_q <= cfg_wdata_i[38:0];
        CFG_USER_END:   user_end_q   <= cfg_wdata_i[39:0];
        CFG_FREE_LOW:   free_low_q   <= cfg_wdata_i[43:0];
        CFG_FREE_END:   free_end_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign well_formed = (in_data_i.vaddr[63:38] == '0) || (in_data_i.vaddr[63:38] == '1);
  assign fault_ok = well_formed && (in_data_i.vaddr >= {25'd0, user_start_q})
                    && (in_data_i.vaddr < {24'd0, user_end_q});
  assign free_ok = (in_data_i.page_number >= free_low_q)
                   && ({1'b0, in_data_i.page_number} < free_end_q);

  assign in_stall_o = q_full_i || clearing_i;
  assign q_push_o = in_valid_i && !in_stall_o && (in_data_i.cmd != 2'd3);

  always_comb begin
    q_data_o.op   = cmd_e'(in_data_i.cmd);
    q_data_o.vpn2 = in_data_i.vaddr[38:30];
    q_data_o.vpn1 = in_data_i.vaddr[29:21];
    q_data_o.vpn0 = in_data_i.vaddr[20:12];
    q_data_o.page = in_data_i.page_number;
    case (in_data_i.cmd)
      CMD_LOOKUP: q_data_o.bad = !well_formed;
      CMD_FAULT:  q_data_o.bad = !fault_ok;
      default:    q_data_o.bad = !free_ok;
    endcase
  end

endmodule

>>> src/swfm_queue.sv
`timescale 1ns / 1ps
// Two-entry request queue between the front end and the walker.
// Depends on swfm_pkg.
module swfm_queue import swfm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output q_entry_t pop_data_o
);

  q_entry_t   mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> src/swfm_back.sv
`timescale 1ns / 1ps
// Back end: page-table store, free page stack, walk sequencer and result register.
// Depends on swfm_pkg.
module swfm_back import swfm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  q_entry_t  q_data_i,
  output logic      q_pop_o,
  output logic      clearing_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_L2    = 7'b0000100,
    S_L1    = 7'b0001000,
    S_L0    = 7'b0010000,
    S_NEW1  = 7'b0100000,
    S_POP   = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [NSLOT_W-1:0] next_q, next_d;
  logic [FCNT_W-1:0]  fcnt_q, fcnt_d;
  logic [SLOT_W-1:0]  t1_q, t1_d;
  logic [SLOT_W-1:0]  t0_q, t0_d;
  q_entry_t           ent_q, ent_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic [PTE_W-1:0]   pte_mem [STORE_DEPTH];
  logic [PTE_W-1:0]   pte_rdata_q;
  logic               pte_re, pte_we;
  logic [ADDR_W-1:0]  pte_raddr, pte_waddr;
  logic [PTE_W-1:0]   pte_wdata;

  logic [PPN_W-1:0]   stk_mem [FREE_DEPTH];
  logic [PPN_W-1:0]   stk_rdata_q;
  logic               stk_re, stk_we;
  logic [FADDR_W-1:0] stk_raddr;
  logic [FCNT_W-1:0]  fcnt_dec;

  logic               out_free;
  logic               rd_ok;
  logic [SLOT_W-1:0]  rd_slot;
  logic [NSLOT_W:0]   slots_after1, slots_after2;
  logic [SLOT_W-1:0]  next_slot;

  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_ok = pte_rdata_q[0] && (pte_rdata_q[51:8] < PPN_W'(TABLE_SLOTS));
  assign rd_slot = pte_rdata_q[8 +: SLOT_W];
  assign slots_after1 = {1'b0, next_q} + (NSLOT_W+1)'(1);
  assign slots_after2 = {1'b0, next_q} + (NSLOT_W+1)'(2);
  assign next_slot = next_q[SLOT_W-1:0];
  assign fcnt_dec = fcnt_q - FCNT_W'(1);

  assign clearing_o = (state_q == S_CLEAR);
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    next_d = next_q;
    fcnt_d = fcnt_q;
    t1_d = t1_q;
    t0_d = t0_q;
    ent_d = ent_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;
    pte_re = 1'b0;
    pte_raddr = '0;
    pte_we = 1'b0;
    pte_waddr = '0;
    pte_wdata = '0;
    stk_re = 1'b0;
    stk_raddr = fcnt_dec[FADDR_W-1:0];
    stk_we = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        pte_we = 1'b1;
        pte_waddr = clr_q;
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_pop_o) begin
          ent_d = q_data_i;
          out_d = '0;
          if (q_data_i.op == CMD_FREE) begin
            out_valid_d = 1'b1;
            if (q_data_i.bad || fcnt_q >= FCNT_W'(FREE_DEPTH)) begin
              out_d.status = ST_REJECTED;
            end else begin
              stk_we = 1'b1;
              fcnt_d = fcnt_q + FCNT_W'(1);
              out_d.status = ST_OK;
            end
          end else if (q_data_i.bad) begin
            out_valid_d = 1'b1;
            out_d.status = (q_data_i.op == CMD_LOOKUP) ? ST_NOT_FOUND : ST_BAD_ADDR;
          end else begin
            pte_re = 1'b1;
            pte_raddr = {SLOT_W'(0), q_data_i.vpn2};
            state_d = S_L2;
          end
        end
      end
      S_L2: begin
        out_d = '0;
        t1_d = rd_slot;
        if (rd_ok) begin
          pte_re = 1'b1;
          pte_raddr = {rd_slot, ent_q.vpn1};
          state_d = S_L1;
        end else if (ent_q.op == CMD_LOOKUP) begin
          out_valid_d = 1'b1;
          out_d.status = ST_NOT_FOUND;
          state_d = S_IDLE;
        end else if (slots_after2 > (NSLOT_W+1)'(TABLE_SLOTS)) begin
          out_valid_d = 1'b1;
          out_d.status = ST_NO_SLOTS;
          state_d = S_IDLE;
        end else begin
          pte_we = 1'b1;
          pte_waddr = {SLOT_W'(0), ent_q.vpn2};
          pte_wdata = {PPN_W'(next_q), FLAG_V};
          t1_d = next_slot;
          next_d = next_q + NSLOT_W'(1);
          state_d = S_NEW1;
        end
      end
      S_NEW1: begin
        out_d = '0;
        pte_we = 1'b1;
        pte_waddr = {t1_q, ent_q.vpn1};
        pte_wdata = {PPN_W'(next_q), FLAG_V};
        t0_d = next_slot;
        next_d = next_q + NSLOT_W'(1);
        if (fcnt_q == '0) begin
          out_valid_d = 1'b1;
          out_d.status = ST_NO_PAGES;
          state_d = S_IDLE;
        end else begin
          stk_re = 1'b1;
          state_d = S_POP;
        end
      end
      S_L1: begin
        out_d = '0;
        t0_d = rd_slot;
        if (rd_ok) begin
          pte_re = 1'b1;
          pte_raddr = {rd_slot, ent_q.vpn0};
          state_d = S_L0;
        end else if (ent_q.op == CMD_LOOKUP) begin
          out_valid_d = 1'b1;
          out_d.status = ST_NOT_FOUND;
          state_d = S_IDLE;
        end else if (slots_after1 > (NSLOT_W+1)'(TABLE_SLOTS)) begin
          out_valid_d = 1'b1;
          out_d.status = ST_NO_SLOTS;
          state_d = S_IDLE;
        end else begin
          pte_we = 1'b1;
          pte_waddr = {t1_q, ent_q.vpn1};
          pte_wdata = {PPN_W'(next_q), FLAG_V};
          t0_d = next_slot;
          next_d = next_q + NSLOT_W'(1);
          if (fcnt_q == '0) begin
            out_valid_d = 1'b1;
            out_d.status = ST_NO_PAGES;
            state_d = S_IDLE;
          end else begin
            stk_re = 1'b1;
            state_d = S_POP;
          end
        end
      end
      S_L0: begin
        out_d = '0;
        if (ent_q.op == CMD_LOOKUP) begin
          out_valid_d = 1'b1;
          out_d.status = ST_OK;
          out_d.leaf_flags = pte_rdata_q[7:0];
          out_d.leaf_page = pte_rdata_q[51:8];
          state_d = S_IDLE;
        end else if (pte_rdata_q[0]) begin
          out_valid_d = 1'b1;
          out_d.status = ST_MAPPED;
          out_d.leaf_flags = pte_rdata_q[7:0];
          out_d.leaf_page = pte_rdata_q[51:8];
          state_d = S_IDLE;
        end else if (fcnt_q == '0) begin
          out_valid_d = 1'b1;
          out_d.status = ST_NO_PAGES;
          state_d = S_IDLE;
        end else begin
          stk_re = 1'b1;
          state_d = S_POP;
        end
      end
      S_POP: begin
        pte_we = 1'b1;
        pte_waddr = {t0_q, ent_q.vpn0};
        pte_wdata = {stk_rdata_q, LEAF_FLAGS};
        fcnt_d = fcnt_dec;
        out_valid_d = 1'b1;
        out_d.status = ST_OK;
        out_d.leaf_flags = LEAF_FLAGS;
        out_d.leaf_page = stk_rdata_q;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      next_q      <= NSLOT_W'(1);
      fcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      next_q      <= next_d;
      fcnt_q      <= fcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= t1_d;
    t0_q  <= t0_d;
    ent_q <= ent_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (pte_we) begin
      pte_mem[pte_waddr] <= pte_wdata;
    end
    if (pte_re) begin
      pte_rdata_q <= pte_mem[pte_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[fcnt_q[FADDR_W-1:0]] <= q_data_i.page;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
  end

endmodule

>>> src/sv39_page_walk_fault_mapper_top.sv
`timescale 1ns / 1ps
// Top level of the Sv39 page walk and fault mapper.
// Depends on swfm_pkg, swfm_front, swfm_queue and swfm_back.
//
// After reset the walker zeroes its page-table store one entry per cycle; requests are
// held off until it is done, while configuration writes are taken at once. Requests
// enter a two-entry queue and are processed one at a time by a walker with one
// single-port table memory with registered reads. A request is registered in the queue
// and then taken by the walker, which answers a free or a rejected request at once, walks
// a lookup through as many of the L2, L1 and L0 table reads as it needs, and serves a page
// fault through the chain of dependent table reads and writes that add missing tables and
// pop a free page. Results wait in an output register while the queue keeps accepting requests.
module sv39_page_walk_fault_mapper_top import swfm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  logic     clearing;
  logic     q_full;
  logic     q_push;
  logic     q_valid;
  logic     q_pop;
  q_entry_t q_push_data;
  q_entry_t q_pop_data;

  swfm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .clearing_i  (clearing),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_push_data)
  );

  swfm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data)
  );

  swfm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_pop_data),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> src/swfm_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the Sv39 page walk and fault mapper, bound to the top level.
// Depends on swfm_pkg.
module swfm_port_props import swfm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled result was dropped.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 3'd7)
    else $error("Result status out of range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_NOT_FOUND || out_data_o.status == ST_BAD_ADDR
      || out_data_o.status == ST_NO_PAGES || out_data_o.status == ST_NO_SLOTS
      || out_data_o.status == ST_REJECTED)
    |-> out_data_o.leaf_flags == 8'd0 && out_data_o.leaf_page == '0)
    else $error("Failed request carries leaf data.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_MAPPED |-> out_data_o.leaf_flags[0])
    else $error("Already-mapped result shows an invalid leaf.");

endmodule

bind sv39_page_walk_fault_mapper_top swfm_port_props u_swfm_port_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
